// ===== src/sws_pkg.sv =====
// ----------------------------------------------------------------------------
// sws_pkg
// Shared constants, codes and helpers of the slow-start window sender.
// ----------------------------------------------------------------------------
`default_nettype none

package sws_pkg;

	localparam int MAX_PACKETS     = 4096;
	localparam int MAX_WINDOW      = 64;
	localparam int RESET_THRESHOLD = 16;

	localparam int SEQ_W  = 13;
	localparam int WIN_W  = 7;
	localparam int BASE_W = 14;
	localparam int CNT_W  = 7;
	localparam int CFG_W  = 13;

	// input command codes
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_ACK   = 2'd1;
	localparam logic [1:0] CMD_END   = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_SEND    = 2'd0;
	localparam logic [1:0] KIND_ACK_OK  = 2'd1;
	localparam logic [1:0] KIND_ACK_BAD = 2'd2;
	localparam logic [1:0] KIND_ROUND   = 2'd3;

	// register indexes
	localparam logic CFG_THRESHOLD = 1'b0;
	localparam logic CFG_PKT_COUNT = 1'b1;

	function automatic logic [WIN_W-1:0] clamp_thr(input logic [WIN_W-1:0] v);
		logic [WIN_W-1:0] r;
		r = v;
		if (v == '0)
			r = WIN_W'(1);
		else if (v > WIN_W'(MAX_WINDOW))
			r = WIN_W'(MAX_WINDOW);
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/sws_ram.sv =====
// ----------------------------------------------------------------------------
// sws_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sws_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== src/sliding_window_slow_start_sender.sv =====
// ----------------------------------------------------------------------------
// sliding_window_slow_start_sender
// Sender window control with slow start: per-packet sent/acked bitmaps,
// window base, window size and threshold, stepped by a small sequencer.
// ----------------------------------------------------------------------------
// Sequence: an ack passes through S_ACK; a start round steps S_SEND_RD and
//   S_SEND_EMIT once per packet sent (up to one window), and returns to idle
//   when nothing is sent; an end round goes to S_OUT, after a shortfall by
//   way of a base search (S_SRCH_RD, S_SRCH_CHK) of up to packet_count entries.
// Throughput: one item at a time; the walk pointer and single RAM read port
//   set the pace. Output register lets the next item start while a result waits.
// Reset: asynchronous, active low. A clearing pass over all MAX_PACKETS entries
//   zeroes both bitmaps before the first item is accepted.
`default_nettype none

module sliding_window_slow_start_sender #(
	parameter int MAX_PACKETS = sws_pkg::MAX_PACKETS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// config write port
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_addr,
	input  wire logic [sws_pkg::CFG_W-1:0] cfg_data,
	// input stream
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire logic [15:0]               s_axis_tdata,  // [12:0] ack_seq
	input  wire logic [1:0]                s_axis_tuser,  // [1:0] command
	// result stream
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	output logic      [31:0]               m_axis_tdata,  // [12:0] seq, [13] resend,
	                                                      // [20:14] window,
	                                                      // [27:21] threshold,
	                                                      // [28] timed_out, [29] done_res
	output logic      [1:0]                m_axis_tuser,  // [1:0] kind
	output logic                           m_axis_tlast
);

	localparam int IDX_W  = $clog2(MAX_PACKETS);
	localparam int SEQ_W  = sws_pkg::SEQ_W;
	localparam int WIN_W  = sws_pkg::WIN_W;
	localparam int BASE_W = sws_pkg::BASE_W;
	localparam int CNT_W  = sws_pkg::CNT_W;

	localparam logic [2:0] S_CLR       = 3'd0;
	localparam logic [2:0] S_IDLE      = 3'd1;
	localparam logic [2:0] S_SEND_RD   = 3'd2;
	localparam logic [2:0] S_SEND_EMIT = 3'd3;
	localparam logic [2:0] S_ACK       = 3'd4;
	localparam logic [2:0] S_SRCH_RD   = 3'd5;
	localparam logic [2:0] S_SRCH_CHK  = 3'd6;
	localparam logic [2:0] S_OUT       = 3'd7;

	logic [2:0]        state_q;
	logic [IDX_W-1:0]  clr_q;
	logic [BASE_W-1:0] ptr_q;
	logic [BASE_W-1:0] base_q;
	logic [WIN_W-1:0]  win_q;
	logic [WIN_W-1:0]  thr_q;
	logic [CNT_W-1:0]  sent_cnt_q;
	logic [SEQ_W-1:0]  ack_cnt_q;
	logic              fin_q;
	logic              tmo_q;
	logic [SEQ_W-1:0]  ack_q;
	logic [SEQ_W-1:0]  pkt_cnt_q;

	logic              out_valid_q;
	logic [1:0]        out_kind_q;
	logic [SEQ_W-1:0]  out_seq_q;
	logic              out_resend_q;
	logic              out_tmo_q;
	logic              out_done_q;
	logic              out_last_q;
	logic [WIN_W-1:0]  out_win_q;
	logic [WIN_W-1:0]  out_thr_q;

	logic [SEQ_W-1:0]  total;
	logic [BASE_W-1:0] total_ext;
	logic [BASE_W-1:0] win_end;
	logic [BASE_W-1:0] ptr_nx;
	logic              send_ok;
	logic              send_last;
	logic [BASE_W-1:0] ack_ext;
	logic [SEQ_W-1:0]  ack_m1;
	logic              ack_hit;
	logic              ack_store;
	logic [WIN_W:0]    win_grow;
	logic [WIN_W-1:0]  win_next;
	logic [WIN_W-1:0]  win_half;
	logic [BASE_W-1:0] base_next;
	logic              out_free;
	logic              out_load;
	logic              in_xfer;

	logic              sent_we;
	logic [IDX_W-1:0]  sent_waddr;
	logic              sent_wdata;
	logic              sent_rdata;
	logic              acked_we;
	logic [IDX_W-1:0]  acked_waddr;
	logic              acked_wdata;
	logic              acked_rdata;
	logic [IDX_W-1:0]  rd_addr;

	always_comb begin
		if (pkt_cnt_q == '0)
			total = SEQ_W'(1);
		else if (32'(pkt_cnt_q) > 32'(MAX_PACKETS))
			total = SEQ_W'(MAX_PACKETS);
		else
			total = pkt_cnt_q;
	end

	assign total_ext = {1'b0, total};
	assign win_end   = base_q + BASE_W'(win_q);
	assign ptr_nx    = ptr_q + BASE_W'(1);
	assign send_ok   = (ptr_q < win_end) && (ptr_q <= total_ext);
	assign send_last = (ptr_nx == win_end) || (ptr_q == total_ext);

	assign ack_ext   = {1'b0, ack_q};
	assign ack_m1    = ack_q - SEQ_W'(1);
	assign ack_hit   = !fin_q && (ack_ext >= base_q) && (ack_ext < win_end);
	assign ack_store = ack_hit && (32'(ack_m1) < 32'(MAX_PACKETS));

	always_comb begin
		if (win_q < thr_q)
			win_grow = {win_q, 1'b0};
		else
			win_grow = {1'b0, win_q} + (WIN_W+1)'(1);
		if (win_grow > (WIN_W+1)'(sws_pkg::MAX_WINDOW))
			win_next = WIN_W'(sws_pkg::MAX_WINDOW);
		else
			win_next = win_grow[WIN_W-1:0];
	end

	assign win_half  = ((win_q >> 1) > WIN_W'(1)) ? (win_q >> 1) : WIN_W'(1);
	assign base_next = base_q + BASE_W'(win_q);

	assign out_free      = !out_valid_q || m_axis_tready;
	assign out_load      = out_free && ((state_q == S_SEND_EMIT) || (state_q == S_ACK) ||
	                                    (state_q == S_OUT));
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// bitmap ports
	assign rd_addr     = IDX_W'(ptr_q - BASE_W'(1));
	assign sent_we     = (state_q == S_CLR) || ((state_q == S_SEND_EMIT) && out_free);
	assign sent_waddr  = (state_q == S_CLR) ? clr_q : rd_addr;
	assign sent_wdata  = (state_q != S_CLR);
	assign acked_we    = (state_q == S_CLR) || ((state_q == S_ACK) && out_free && ack_store);
	assign acked_waddr = (state_q == S_CLR) ? clr_q : IDX_W'(ack_m1);
	assign acked_wdata = (state_q != S_CLR);

	sws_ram #(
		.WIDTH(1),
		.DEPTH(MAX_PACKETS)
	) u_sent_ram (
		.clk  (clk),
		.we   (sent_we),
		.waddr(sent_waddr),
		.wdata(sent_wdata),
		.raddr(rd_addr),
		.rdata(sent_rdata)
	);

	sws_ram #(
		.WIDTH(1),
		.DEPTH(MAX_PACKETS)
	) u_acked_ram (
		.clk  (clk),
		.we   (acked_we),
		.waddr(acked_waddr),
		.wdata(acked_wdata),
		.raddr(rd_addr),
		.rdata(acked_rdata)
	);

	// sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			ptr_q       <= BASE_W'(1);
			base_q      <= BASE_W'(1);
			win_q       <= WIN_W'(1);
			thr_q       <= sws_pkg::clamp_thr(WIN_W'(sws_pkg::RESET_THRESHOLD));
			sent_cnt_q  <= '0;
			ack_cnt_q   <= '0;
			fin_q       <= 1'b0;
			tmo_q       <= 1'b0;
			ack_q       <= '0;
			pkt_cnt_q   <= SEQ_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(MAX_PACKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end

				S_IDLE: begin
					if (in_xfer) begin
						ack_q <= s_axis_tdata[SEQ_W-1:0];
						unique case (s_axis_tuser)
							sws_pkg::CMD_START: begin
								sent_cnt_q <= '0;
								ack_cnt_q  <= '0;
								ptr_q      <= base_q;
								state_q    <= fin_q ? S_IDLE : S_SEND_RD;
							end
							sws_pkg::CMD_ACK: begin
								state_q <= S_ACK;
							end
							sws_pkg::CMD_END: begin
								if (fin_q) begin
									tmo_q   <= 1'b0;
									state_q <= S_OUT;
								end else if (ack_cnt_q < SEQ_W'(sent_cnt_q)) begin
									tmo_q      <= 1'b1;
									thr_q      <= win_half;
									win_q      <= WIN_W'(1);
									ptr_q      <= base_q;
									sent_cnt_q <= '0;
									ack_cnt_q  <= '0;
									state_q    <= S_SRCH_RD;
								end else begin
									tmo_q      <= 1'b0;
									base_q     <= base_next;
									win_q      <= win_next;
									fin_q      <= (base_next > total_ext);
									sent_cnt_q <= '0;
									ack_cnt_q  <= '0;
									state_q    <= S_OUT;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end

				S_SEND_RD: begin
					state_q <= send_ok ? S_SEND_EMIT : S_IDLE;
				end

				S_SEND_EMIT: begin
					if (out_free) begin
						sent_cnt_q  <= sent_cnt_q + CNT_W'(1);
						ptr_q       <= ptr_nx;
						state_q     <= send_last ? S_IDLE : S_SEND_RD;
					end
				end

				S_ACK: begin
					if (out_free) begin
						if (ack_hit && (ack_cnt_q != '1)) begin
							ack_cnt_q <= ack_cnt_q + SEQ_W'(1);
						end
						state_q <= S_IDLE;
					end
				end

				S_SRCH_RD: begin
					if (ptr_q > total_ext) begin
						fin_q   <= 1'b1;
						state_q <= S_OUT;
					end else begin
						state_q <= S_SRCH_CHK;
					end
				end

				S_SRCH_CHK: begin
					if (!acked_rdata) begin
						base_q  <= ptr_q;
						state_q <= S_OUT;
					end else begin
						ptr_q   <= ptr_nx;
						state_q <= S_SRCH_RD;
					end
				end

				S_OUT: begin
					if (out_free) begin
						state_q     <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (cfg_we) begin
				if (cfg_addr == sws_pkg::CFG_THRESHOLD) begin
					thr_q <= sws_pkg::clamp_thr(cfg_data[WIN_W-1:0]);
				end else begin
					pkt_cnt_q <= cfg_data[SEQ_W-1:0];
				end
			end
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_win_q    <= win_q;
			out_thr_q    <= thr_q;
			out_done_q   <= fin_q;
			unique case (state_q)
				S_SEND_EMIT: begin
					out_kind_q   <= sws_pkg::KIND_SEND;
					out_seq_q    <= ptr_q[SEQ_W-1:0];
					out_resend_q <= sent_rdata;
					out_tmo_q    <= 1'b0;
					out_last_q   <= send_last;
				end
				S_ACK: begin
					out_kind_q   <= ack_hit ? sws_pkg::KIND_ACK_OK : sws_pkg::KIND_ACK_BAD;
					out_seq_q    <= ack_q;
					out_resend_q <= 1'b0;
					out_tmo_q    <= 1'b0;
					out_last_q   <= 1'b1;
				end
				default: begin
					out_kind_q   <= sws_pkg::KIND_ROUND;
					out_seq_q    <= base_q[SEQ_W-1:0];
					out_resend_q <= 1'b0;
					out_tmo_q    <= tmo_q;
					out_last_q   <= 1'b1;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {2'b00, out_done_q, out_tmo_q, out_thr_q, out_win_q,
	                        out_resend_q, out_seq_q};

	a_win_range: assert property (@(posedge clk) disable iff (!arst_n)
		(win_q != '0) && (win_q <= WIN_W'(sws_pkg::MAX_WINDOW)))
		else $error("window out of range");

	a_thr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(thr_q != '0) && (thr_q <= WIN_W'(sws_pkg::MAX_WINDOW)))
		else $error("threshold out of range");

	a_sent_le_win: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (sent_cnt_q <= CNT_W'(win_q)))
		else $error("more sends than window");

	a_srch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH_CHK) |-> (ptr_q <= total_ext) && (ptr_q >= base_q))
		else $error("base search outside packets");

	a_base_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(base_q != '0))
		else $error("window base is zero");

endmodule

`default_nettype wire

// ===== tb/sv/sliding_window_slow_start_sender_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_slow_start_sender_tb
// Self-checking bench for the slow-start window sender. A behavioral model of
// the window, threshold and sent/acked maps predicts every result transfer as
// each command is accepted; a monitor compares the result stream field by
// field. Directed tests cover reset settings, register clamping, round
// outcomes and empty windows. Random rounds then run under several
// idle/stall mixes, the base is walked to the top of the packet space, and
// the transfer is driven to completion.
// ----------------------------------------------------------------------------

module sliding_window_slow_start_sender_tb;
	import sws_pkg::*;

	localparam int          CYCLE_LIMIT      = 2000000;
	localparam int          TAIL_CYCLES      = 16;
	localparam int          PHASE_ITEMS      = 50;
	localparam int          NOISE_END_LIMIT  = 2500;
	localparam int unsigned ACK_COUNT_MAX    = 8191;
	localparam int unsigned LATE_BASE        = MAX_PACKETS - MAX_WINDOW + 2;
	localparam int          MAX_PRINTS       = 40;

	typedef struct packed {
		logic [1:0]       kind;
		logic [SEQ_W-1:0] seq;
		logic             resend;
		logic [WIN_W-1:0] window;
		logic [WIN_W-1:0] threshold;
		logic             timed_out;
		logic             done_res;
		logic             is_last;
	} sws_result_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_addr;
	logic [CFG_W-1:0] cfg_data;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [15:0]      s_axis_tdata;   // [12:0] ack_seq
	logic [1:0]       s_axis_tuser;   // [1:0] command
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [31:0]      m_axis_tdata;   // [12:0] seq, [13] resend, [20:14] window,
	                                  // [27:21] threshold, [28] timed_out, [29] done_res
	logic [1:0]       m_axis_tuser;   // [1:0] kind
	logic             m_axis_tlast;

	// window model state
	bit               acked_map [0:MAX_PACKETS-1];
	bit               sent_map [0:MAX_PACKETS-1];
	int unsigned      win_base;
	int unsigned      cwnd;
	int unsigned      ss_thresh;
	int unsigned      sent_in_round;
	int unsigned      acks_in_round;
	bit               xfer_done;
	int unsigned      thr_setting;
	int unsigned      pkt_setting;

	sws_result_t      due_results[$];
	int               mismatch_count;
	int               result_count;
	int unsigned      item_count;
	int               gap_pct;
	int               stall_pct;
	int               cycle_count;

	sliding_window_slow_start_sender DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic int unsigned used_total();
		int unsigned n;
		n = pkt_setting;
		if (n < 1)
			n = 1;
		if (n > MAX_PACKETS)
			n = MAX_PACKETS;
		return n;
	endfunction

	function automatic void expect_result(input logic [1:0] kind, input int unsigned seq,
			input bit resend, input bit tmo, input bit is_last);
		sws_result_t r;
		r.kind      = kind;
		r.seq       = SEQ_W'(seq);
		r.resend    = resend;
		r.window    = WIN_W'(cwnd);
		r.threshold = WIN_W'(ss_thresh);
		r.timed_out = tmo;
		r.done_res  = xfer_done;
		r.is_last   = is_last;
		due_results.push_back(r);
	endfunction

	function automatic void apply_command(input logic [1:0] cmd, input logic [SEQ_W-1:0] ack);
		int unsigned total;
		int unsigned hi;
		int unsigned i;
		int unsigned a;
		bit          found;
		bit          tmo;
		total = used_total();
		a     = 32'(ack);
		tmo   = 1'b0;
		case (cmd)
			CMD_START: begin
				sent_in_round = 0;
				acks_in_round = 0;
				if (!xfer_done) begin
					hi = win_base + cwnd - 1;
					if (hi > total)
						hi = total;
					for (i = win_base; i <= hi; i++) begin
						expect_result(KIND_SEND, i, sent_map[i-1], 1'b0, i == hi);
						sent_map[i-1] = 1'b1;
						sent_in_round++;
					end
				end
			end
			CMD_ACK: begin
				if (!xfer_done && a >= win_base && a < win_base + cwnd) begin
					if (a >= 1 && a - 1 < MAX_PACKETS)
						acked_map[a-1] = 1'b1;
					if (acks_in_round < ACK_COUNT_MAX)
						acks_in_round++;
					expect_result(KIND_ACK_OK, a, 1'b0, 1'b0, 1'b1);
				end else begin
					expect_result(KIND_ACK_BAD, a, 1'b0, 1'b0, 1'b1);
				end
			end
			CMD_END: begin
				if (!xfer_done) begin
					if (acks_in_round < sent_in_round) begin
						tmo       = 1'b1;
						ss_thresh = (cwnd / 2 > 1) ? cwnd / 2 : 1;
						cwnd      = 1;
						found     = 1'b0;
						for (i = win_base; i <= total && !found; i++) begin
							if (!acked_map[i-1]) begin
								win_base = i;
								found    = 1'b1;
							end
						end
						if (!found)
							xfer_done = 1'b1;
					end else begin
						win_base += cwnd;
						if (cwnd < ss_thresh)
							cwnd *= 2;
						else
							cwnd += 1;
						if (cwnd > MAX_WINDOW)
							cwnd = MAX_WINDOW;
						if (win_base > total)
							xfer_done = 1'b1;
					end
					sent_in_round = 0;
					acks_in_round = 0;
				end
				expect_result(KIND_ROUND, win_base, 1'b0, tmo, 1'b1);
			end
			default: ;
		endcase
	endfunction

	task automatic flag_mismatch(input string msg);
		if (mismatch_count < MAX_PRINTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic compare_field(input string name, input int got, input int want);
		if (got != want)
			flag_mismatch($sformatf("result %0d %s got %0d expected %0d",
				result_count, name, got, want));
	endtask

	always @(posedge clk) begin : result_monitor
		sws_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (due_results.size() == 0) begin
				flag_mismatch($sformatf("result %0d kind %0d seq %0d with nothing due",
					result_count, m_axis_tuser, m_axis_tdata[12:0]));
			end else begin
				want = due_results.pop_front();
				compare_field("kind", int'(m_axis_tuser), int'(want.kind));
				compare_field("seq", int'(m_axis_tdata[12:0]), int'(want.seq));
				compare_field("resend", int'(m_axis_tdata[13]), int'(want.resend));
				compare_field("window", int'(m_axis_tdata[20:14]), int'(want.window));
				compare_field("threshold", int'(m_axis_tdata[27:21]), int'(want.threshold));
				compare_field("timed_out", int'(m_axis_tdata[28]), int'(want.timed_out));
				compare_field("done_res", int'(m_axis_tdata[29]), int'(want.done_res));
				compare_field("tlast", int'(m_axis_tlast), int'(want.is_last));
			end
			result_count++;
		end
	end

	task automatic send_item(input logic [1:0] cmd, input int unsigned seq);
		while ($urandom_range(99) < gap_pct) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {3'b000, SEQ_W'(seq)};
		do
			@(posedge clk);
		while (!s_axis_tready);
		apply_command(cmd, SEQ_W'(seq));
		if (cmd != CMD_NOP)
			item_count++;
	endtask

	// hold off until every due result has arrived, plus room for silent commands
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic addr, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (addr == CFG_THRESHOLD) begin
			thr_setting = 32'(data[WIN_W-1:0]);
			ss_thresh   = thr_setting < 1 ? 1 :
				(thr_setting > MAX_WINDOW ? MAX_WINDOW : thr_setting);
		end else begin
			pkt_setting = 32'(data);
		end
	endtask

	task automatic run_round();
		int unsigned b;
		int unsigned hi;
		int unsigned lo;
		int unsigned n;
		int unsigned i;
		b  = win_base;
		hi = b + cwnd - 1;
		if (hi > used_total())
			hi = used_total();
		send_item(CMD_START, $urandom_range(8191));
		if ($urandom_range(99) < 60) begin
			for (i = b; i <= hi; i++)
				if ($urandom_range(99) >= 4)
					send_item(CMD_ACK, i);
		end else begin
			lo = (b > 2) ? b - 2 : 0;
			n  = $urandom_range(hi - b + 3, 0);
			repeat (n) send_item(CMD_ACK, $urandom_range(b + cwnd + 1, lo));
		end
		if ($urandom_range(99) < 5)
			settle();
		send_item(CMD_END, $urandom_range(8191));
	endtask

	task automatic test_reset_defaults();
		send_item(CMD_NOP, 0);
		send_item(CMD_START, 0);
		send_item(CMD_ACK, 0);
		send_item(CMD_ACK, 1);
		send_item(CMD_ACK, 1);
		send_item(CMD_ACK, 'h1FFF);
		send_item(CMD_START, 'h1FFF);
		send_item(CMD_NOP, 'h1FFF);
		settle();
	endtask

	task automatic test_register_clamps();
		write_reg(CFG_THRESHOLD, 13'd127);
		write_reg(CFG_THRESHOLD, 13'd0);
		write_reg(CFG_PKT_COUNT, 13'd0);
		send_item(CMD_START, 0);
		settle();
		write_reg(CFG_PKT_COUNT, 13'h1FFF);
		write_reg(CFG_THRESHOLD, 13'd2);
	endtask

	task automatic test_round_outcomes();
		send_item(CMD_START, 0);
		send_item(CMD_ACK, 1);
		send_item(CMD_END, 0);
		send_item(CMD_START, 0);
		send_item(CMD_ACK, 2);
		send_item(CMD_ACK, 3);
		send_item(CMD_END, 0);
		// partial acks: shortfall, threshold halves, base moves to first hole
		send_item(CMD_START, 0);
		send_item(CMD_ACK, 4);
		send_item(CMD_END, 0);
		send_item(CMD_START, 0);
		send_item(CMD_END, 0);
		// no start round: nothing sent, counts as success
		send_item(CMD_END, 0);
	endtask

	task automatic test_empty_window();
		settle();
		write_reg(CFG_PKT_COUNT, 13'd3);
		send_item(CMD_START, 0);
		send_item(CMD_ACK, win_base);
		send_item(CMD_ACK, win_base + cwnd - 1);
		settle();
		write_reg(CFG_PKT_COUNT, 13'(MAX_PACKETS));
	endtask

	task automatic test_random_rounds(input int idle_in, input int stall_in,
			input logic [CFG_W-1:0] thr_value);
		int unsigned first;
		logic [1:0]  cmd;
		settle();
		write_reg(CFG_THRESHOLD, thr_value);
		gap_pct   = idle_in;
		stall_pct = stall_in;
		first     = item_count;
		while (item_count - first < PHASE_ITEMS) begin
			if ($urandom_range(99) < 80) begin
				run_round();
			end else begin
				cmd = 2'($urandom_range(3));
				if (cmd == CMD_END && win_base > NOISE_END_LIMIT)
					cmd = CMD_ACK;
				send_item(cmd, $urandom_range(8191));
			end
		end
	endtask

	task automatic test_reach_last_packets();
		settle();
		gap_pct   = 0;
		stall_pct = 0;
		send_item(CMD_START, 0);
		send_item(CMD_END, 0);
		// once the window is full, bases step by 64; keep them off the one
		// value that would jump straight past the last packet
		while (((win_base + MAX_WINDOW - 1) % MAX_WINDOW) == ((LATE_BASE - 1) % MAX_WINDOW)) begin
			send_item(CMD_START, 0);
			send_item(CMD_ACK, win_base);
			send_item(CMD_START, 0);
			send_item(CMD_END, 0);
		end
		settle();
		write_reg(CFG_THRESHOLD, 13'(MAX_WINDOW));
		while (win_base < LATE_BASE)
			send_item(CMD_END, $urandom_range(8191));
	endtask

	task automatic test_finish();
		int unsigned b;
		int unsigned i;
		gap_pct   = 35;
		stall_pct = 35;
		b = win_base;
		send_item(CMD_START, 0);
		for (i = b; i < b + MAX_WINDOW; i++)
			send_item(CMD_ACK, i);
		send_item(CMD_ACK, b + MAX_WINDOW);
		settle();
		send_item(CMD_START, 0);
		send_item(CMD_END, 0);
		send_item(CMD_START, 0);
		send_item(CMD_ACK, b);
		send_item(CMD_END, 0);
		send_item(CMD_NOP, 0);
	endtask

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** sliding_window_slow_start_sender: FAILED **");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_addr       = 1'b0;
		cfg_data       = '0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = '0;
		m_axis_tready  = 1'b0;
		gap_pct        = 0;
		stall_pct      = 0;
		mismatch_count = 0;
		result_count   = 0;
		item_count     = 0;
		thr_setting    = RESET_THRESHOLD;
		pkt_setting    = 1;
		win_base       = 1;
		cwnd           = 1;
		ss_thresh      = RESET_THRESHOLD;
		sent_in_round  = 0;
		acks_in_round  = 0;
		xfer_done      = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_register_clamps();
		test_round_outcomes();
		test_empty_window();
		test_random_rounds(0, 0, 13'(MAX_WINDOW));
		test_random_rounds(82, 0, 13'($urandom_range(MAX_WINDOW - 1, 2)));
		test_random_rounds(0, 82, 13'd1);
		test_random_rounds(35, 35, 13'd127);
		test_reach_last_packets();
		test_finish();
		settle();

		if (mismatch_count == 0)
			$display("** sliding_window_slow_start_sender: PASSED **");
		else
			$display("** sliding_window_slow_start_sender: FAILED **");
		$finish;
	end

endmodule
